// ===== rtl/three_axis_pid_velocity_core_defines.svh =====
// Assertion macros shared by the PID velocity core.
`ifndef THREE_AXIS_PID_VELOCITY_CORE_DEFINES_SVH
`define THREE_AXIS_PID_VELOCITY_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define PVC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk and disabled during reset.
`define PVC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PVC_ASSERT_IMP(lbl, ante, cons, msg)
`define PVC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/pvc_pkg.sv =====
// Types, constants and the control program of the PID velocity core.
`timescale 1ns / 1ps
package pvc_pkg;

    // Program counter of the control sequencer.
    typedef logic [3:0] step_t;

    // Program layout: one pass over steps ERR..CLAMP per axis.
    localparam step_t STEP_ERR   = 4'd0;
    localparam step_t STEP_UPD   = 4'd1;
    localparam step_t STEP_DIV   = 4'd2;
    localparam step_t STEP_RATE  = 4'd3;
    localparam step_t STEP_P_HI  = 4'd4;
    localparam step_t STEP_P_LO  = 4'd5;
    localparam step_t STEP_I_HI  = 4'd6;
    localparam step_t STEP_I_LO  = 4'd7;
    localparam step_t STEP_D_HI  = 4'd8;
    localparam step_t STEP_D_LO  = 4'd9;
    localparam step_t STEP_FIN   = 4'd10;
    localparam step_t STEP_CLAMP = 4'd11;
    localparam step_t STEP_OUT   = 4'd12;
    localparam step_t STEP_IDLE  = 4'd13;
    localparam step_t STEP_LAST  = 4'd13;

    // Axis codes.
    localparam logic [1:0] AX_X   = 2'd0;
    localparam logic [1:0] AX_Y   = 2'd1;
    localparam logic [1:0] AX_YAW = 2'd2;

    // Divider runs one quotient bit per cycle over a 49-bit dividend.
    localparam logic [5:0] DIV_STEPS = 6'd49;

    // Saturation bounds.
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

    // Register reset values.
    localparam logic [31:0] RST_LIN_P   = 32'd8388608;
    localparam logic [31:0] RST_LIN_I   = 32'd1678;
    localparam logic [31:0] RST_LIN_D   = 32'd167772;
    localparam logic [31:0] RST_ANG_P   = 32'd1677722;
    localparam logic [31:0] RST_ANG_I   = 32'd1678;
    localparam logic [31:0] RST_ANG_D   = 32'd167772;
    localparam logic [30:0] RST_LIN_LIM = 31'd32768;
    localparam logic [30:0] RST_ANG_LIM = 31'd150733;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_LIN_P   = 3'd0,
        CFG_LIN_I   = 3'd1,
        CFG_LIN_D   = 3'd2,
        CFG_ANG_P   = 3'd3,
        CFG_ANG_I   = 3'd4,
        CFG_ANG_D   = 3'd5,
        CFG_LIN_LIM = 3'd6,
        CFG_ANG_LIM = 3'd7
    } cfg_idx_t;

    // Datapath operation of a step.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_ERR,
        OP_UPD,
        OP_DIV,
        OP_RATE,
        OP_CLAMP,
        OP_OUT
    } dp_op_t;

    // Multiplier half: upper signed or lower unsigned 24 bits of the operand.
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_HI,
        MUL_LO
    } mul_op_t;

    // Multiplier operand source.
    typedef enum logic [1:0] {
        OPS_ERR,
        OPS_SUM,
        OPS_RATE
    } opsel_t;

    // Gain source.
    typedef enum logic [1:0] {
        GAIN_P,
        GAIN_I,
        GAIN_D
    } gsel_t;

    // Accumulator operation.
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_FULL,
        ACC_SHIFT
    } acc_op_t;

    // Jump conditions: when true the sequencer goes to the target step.
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_WAIT_IN,
        JC_DIV_BUSY,
        JC_AX_MORE,
        JC_OUT_BUSY
    } jcond_t;

    // One control word of the program.
    typedef struct packed {
        dp_op_t  dp;
        mul_op_t mul;
        opsel_t  opsel;
        gsel_t   gsel;
        acc_op_t acc;
        jcond_t  jc;
        step_t   target;
    } ctrl_t;

    // Status fed back from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic ax_more;
        logic out_busy;
    } seq_cond_t;

    // Builds a control word.
    function automatic ctrl_t cw(input dp_op_t dp, input mul_op_t mul, input opsel_t opsel,
                                 input gsel_t gsel, input acc_op_t acc, input jcond_t jc,
                                 input step_t target);
        ctrl_t w;
        w.dp     = dp;
        w.mul    = mul;
        w.opsel  = opsel;
        w.gsel   = gsel;
        w.acc    = acc;
        w.jc     = jc;
        w.target = target;
        return w;
    endfunction

    // Control store.
    function automatic ctrl_t ctrl_rom(input step_t step);
        ctrl_t w;
        unique case (step)
            STEP_ERR:   w = cw(OP_ERR, MUL_NONE, OPS_ERR, GAIN_P, ACC_HOLD, JC_NEXT,
                               STEP_ERR);
            STEP_UPD:   w = cw(OP_UPD, MUL_NONE, OPS_ERR, GAIN_P, ACC_HOLD, JC_NEXT,
                               STEP_ERR);
            STEP_DIV:   w = cw(OP_DIV, MUL_NONE, OPS_ERR, GAIN_P, ACC_HOLD, JC_DIV_BUSY,
                               STEP_DIV);
            STEP_RATE:  w = cw(OP_RATE, MUL_NONE, OPS_ERR, GAIN_P, ACC_CLR, JC_NEXT,
                               STEP_ERR);
            STEP_P_HI:  w = cw(OP_NOP, MUL_HI, OPS_ERR, GAIN_P, ACC_HOLD, JC_NEXT,
                               STEP_ERR);
            STEP_P_LO:  w = cw(OP_NOP, MUL_LO, OPS_ERR, GAIN_P, ACC_FULL, JC_NEXT,
                               STEP_ERR);
            STEP_I_HI:  w = cw(OP_NOP, MUL_HI, OPS_SUM, GAIN_I, ACC_SHIFT, JC_NEXT,
                               STEP_ERR);
            STEP_I_LO:  w = cw(OP_NOP, MUL_LO, OPS_SUM, GAIN_I, ACC_FULL, JC_NEXT,
                               STEP_ERR);
            STEP_D_HI:  w = cw(OP_NOP, MUL_HI, OPS_RATE, GAIN_D, ACC_SHIFT, JC_NEXT,
                               STEP_ERR);
            STEP_D_LO:  w = cw(OP_NOP, MUL_LO, OPS_RATE, GAIN_D, ACC_FULL, JC_NEXT,
                               STEP_ERR);
            STEP_FIN:   w = cw(OP_NOP, MUL_NONE, OPS_ERR, GAIN_P, ACC_SHIFT, JC_NEXT,
                               STEP_ERR);
            STEP_CLAMP: w = cw(OP_CLAMP, MUL_NONE, OPS_ERR, GAIN_P, ACC_HOLD, JC_AX_MORE,
                               STEP_ERR);
            STEP_OUT:   w = cw(OP_OUT, MUL_NONE, OPS_ERR, GAIN_P, ACC_HOLD, JC_OUT_BUSY,
                               STEP_OUT);
            STEP_IDLE:  w = cw(OP_LOAD, MUL_NONE, OPS_ERR, GAIN_P, ACC_HOLD, JC_WAIT_IN,
                               STEP_IDLE);
            default:    w = cw(OP_NOP, MUL_NONE, OPS_ERR, GAIN_P, ACC_HOLD, JC_ALWAYS,
                               STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/pvc_seq.sv =====
// Control sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps
module pvc_seq
    import pvc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  seq_cond_t cond,
    output ctrl_t     ctrl
);

    step_t pc_reg;
    step_t pc_next;
    logic  take;

    // Control word of the current step.
    assign ctrl = ctrl_rom(pc_reg);

    // Jump condition and next step.
    always_comb
    begin
        unique case (ctrl.jc)
            JC_NEXT:     take = 1'b0;
            JC_ALWAYS:   take = 1'b1;
            JC_WAIT_IN:  take = !cond.in_valid;
            JC_DIV_BUSY: take = cond.div_busy;
            JC_AX_MORE:  take = cond.ax_more;
            JC_OUT_BUSY: take = cond.out_busy;
            default:     take = 1'b0;
        endcase
        if (take)
        begin
            pc_next = ctrl.target;
        end
        else if (pc_reg == STEP_LAST)
        begin
            pc_next = STEP_ERR;
        end
        else
        begin
            pc_next = pc_reg + 4'd1;
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/pvc_mac.sv =====
// Shared multiply-accumulate unit for the gain products.
`timescale 1ns / 1ps
module pvc_mac
    import pvc_pkg::*;
(
    input  logic                clk,
    input  mul_op_t             mul_op,
    input  acc_op_t             acc_op,
    input  logic signed [47:0]  operand,
    input  logic        [31:0]  gain,
    output logic signed [59:0]  acc
);

    logic signed [24:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [57:0] prod_full;
    logic signed [57:0] prod_reg;
    logic signed [59:0] acc_reg;
    logic signed [59:0] acc_next;

    // Operand half: the upper half is signed, the lower half is unsigned.
    always_comb
    begin
        case (mul_op)
            MUL_HI:  mul_a = {operand[47], operand[47:24]};
            MUL_LO:  mul_a = {1'b0, operand[23:0]};
            default: mul_a = 25'sd0;
        endcase
    end

    assign mul_b     = {1'b0, gain};
    assign prod_full = mul_a * mul_b;

    // Product register.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full;
    end

    // Accumulator: the upper-half product counts in full, the lower-half
    // product is floored by the gain's 24 fraction bits.
    always_comb
    begin
        case (acc_op)
            ACC_CLR:   acc_next = 60'sd0;
            ACC_FULL:  acc_next = acc_reg + {{2{prod_reg[57]}}, prod_reg};
            ACC_SHIFT: acc_next = acc_reg + {{26{prod_reg[57]}}, prod_reg[57:24]};
            default:   acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/three_axis_pid_velocity_core.sv =====
// Top level of the three-axis PID velocity core with output clamp.
// Each word runs the x, y and yaw axis steps in turn, then the output step; no new word
// is accepted before the output step loads the output register. Each axis passes in turn
// through the shared one-bit-per-cycle rate divider.
// Reset clears the errors, sums and handshakes and loads the register defaults.
`timescale 1ns / 1ps
`include "three_axis_pid_velocity_core_defines.svh"
module three_axis_pid_velocity_core
    import pvc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic        [2:0]  cfg_addr,
    input  logic        [31:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] goal_x,
    input  logic signed [31:0] goal_y,
    input  logic signed [31:0] goal_yaw,
    input  logic signed [31:0] meas_x,
    input  logic signed [31:0] meas_y,
    input  logic signed [31:0] meas_yaw,
    input  logic        [30:0] step_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_yaw,
    output logic               zero_time
);

    // Configuration registers.
    logic [31:0] lin_p_reg, lin_i_reg, lin_d_reg;
    logic [31:0] ang_p_reg, ang_i_reg, ang_d_reg;
    logic [30:0] lin_lim_reg, ang_lim_reg;

    // Latched input word and axis counter.
    logic signed [31:0] goal_reg [3];
    logic signed [31:0] meas_reg [3];
    logic        [30:0] dt_reg;
    logic        [1:0]  ax_reg;

    // Per-axis controller state.
    logic signed [31:0] last_reg [3];
    logic signed [47:0] sum_reg  [3];

    // Working registers.
    logic signed [31:0] err_reg;
    logic        [30:0] rem_reg;
    logic        [48:0] num_reg;
    logic               neg_reg;
    logic        [5:0]  div_cnt_reg;
    logic signed [47:0] rate_reg;
    logic signed [31:0] velw_reg [3];

    // Output register.
    logic signed [31:0] vel_x_reg, vel_y_reg, vel_yaw_reg;
    logic               zero_reg;
    logic               out_valid_reg;

    ctrl_t     ctrl;
    seq_cond_t cond;
    logic      in_fire;

    logic signed [31:0] goal_sel, meas_sel, last_sel;
    logic signed [47:0] sum_sel;
    logic signed [32:0] err_wide;
    logic signed [31:0] err_sat;
    logic signed [48:0] sum_wide;
    logic signed [47:0] sum_sat;
    logic signed [32:0] dif;
    logic        [32:0] dif_mag;
    logic        [31:0] trial;
    logic        [31:0] div_sub;
    logic               div_ge;
    logic        [49:0] q_wide;
    logic signed [47:0] rate_sat;
    logic signed [47:0] operand;
    logic        [31:0] gain;
    logic               is_yaw;
    logic        [30:0] lim_sel;
    logic signed [59:0] lim_pos, lim_neg;
    logic signed [59:0] acc;
    logic signed [31:0] clamp_val;

    // Sequencer and multiply-accumulate unit.
    pvc_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    pvc_mac u_mac
    (
        .clk     (clk),
        .mul_op  (ctrl.mul),
        .acc_op  (ctrl.acc),
        .operand (operand),
        .gain    (gain),
        .acc     (acc)
    );

    // Handshakes and sequencer status.
    assign in_ready      = (ctrl.dp == OP_LOAD);
    assign in_fire       = in_valid && in_ready;
    assign cond.in_valid = in_valid;
    assign cond.div_busy = (div_cnt_reg != 6'd1);
    assign cond.ax_more  = (ax_reg != AX_YAW);
    assign cond.out_busy = out_valid_reg && !out_ready;

    assign is_yaw   = (ax_reg == AX_YAW);
    assign goal_sel = goal_reg[ax_reg];
    assign meas_sel = meas_reg[ax_reg];
    assign last_sel = last_reg[ax_reg];
    assign sum_sel  = sum_reg[ax_reg];

    // Error, saturated to 32 bits.
    always_comb
    begin
        err_wide = {goal_sel[31], goal_sel} - {meas_sel[31], meas_sel};
        if (err_wide[32] != err_wide[31])
        begin
            err_sat = err_wide[32] ? S32_MIN : S32_MAX;
        end
        else
        begin
            err_sat = err_wide[31:0];
        end
    end

    // Running sum, saturated to 48 bits, and the error difference.
    always_comb
    begin
        sum_wide = {sum_sel[47], sum_sel} + {{17{err_reg[31]}}, err_reg};
        if (sum_wide[48] != sum_wide[47])
        begin
            sum_sat = sum_wide[48] ? S48_MIN : S48_MAX;
        end
        else
        begin
            sum_sat = sum_wide[47:0];
        end
        dif     = {err_reg[31], err_reg} - {last_sel[31], last_sel};
        dif_mag = dif[32] ? (33'd0 - dif) : dif;
    end

    // One restoring division step on magnitudes.
    assign trial   = {rem_reg, num_reg[48]};
    assign div_ge  = (trial >= {1'b0, dt_reg});
    assign div_sub = trial - {1'b0, dt_reg};

    // Signed quotient truncated toward zero, saturated to 48 bits.
    always_comb
    begin
        q_wide = neg_reg ? (50'd0 - {1'b0, num_reg}) : {1'b0, num_reg};
        if ((q_wide[49:47] == 3'b000) || (q_wide[49:47] == 3'b111))
        begin
            rate_sat = q_wide[47:0];
        end
        else
        begin
            rate_sat = q_wide[49] ? S48_MIN : S48_MAX;
        end
    end

    // Multiplier operand and gain selection.
    always_comb
    begin
        case (ctrl.opsel)
            OPS_SUM:  operand = sum_sel;
            OPS_RATE: operand = rate_reg;
            default:  operand = {{16{err_reg[31]}}, err_reg};
        endcase
        case (ctrl.gsel)
            GAIN_I:  gain = is_yaw ? ang_i_reg : lin_i_reg;
            GAIN_D:  gain = is_yaw ? ang_d_reg : lin_d_reg;
            default: gain = is_yaw ? ang_p_reg : lin_p_reg;
        endcase
    end

    // Output clamp to plus or minus the axis limit.
    always_comb
    begin
        lim_sel = is_yaw ? ang_lim_reg : lin_lim_reg;
        lim_pos = {29'd0, lim_sel};
        lim_neg = 60'sd0 - lim_pos;
        if (acc > lim_pos)
        begin
            clamp_val = {1'b0, lim_sel};
        end
        else if (acc < lim_neg)
        begin
            clamp_val = 32'd0 - {1'b0, lim_sel};
        end
        else
        begin
            clamp_val = acc[31:0];
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_p_reg   <= RST_LIN_P;
            lin_i_reg   <= RST_LIN_I;
            lin_d_reg   <= RST_LIN_D;
            ang_p_reg   <= RST_ANG_P;
            ang_i_reg   <= RST_ANG_I;
            ang_d_reg   <= RST_ANG_D;
            lin_lim_reg <= RST_LIN_LIM;
            ang_lim_reg <= RST_ANG_LIM;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_LIN_P:   lin_p_reg   <= cfg_data;
                CFG_LIN_I:   lin_i_reg   <= cfg_data;
                CFG_LIN_D:   lin_d_reg   <= cfg_data;
                CFG_ANG_P:   ang_p_reg   <= cfg_data;
                CFG_ANG_I:   ang_i_reg   <= cfg_data;
                CFG_ANG_D:   ang_d_reg   <= cfg_data;
                CFG_LIN_LIM: lin_lim_reg <= cfg_data[30:0];
                CFG_ANG_LIM: ang_lim_reg <= cfg_data[30:0];
                default:     ;
            endcase
        end
    end

    // Input word latch.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            goal_reg[AX_X]   <= goal_x;
            goal_reg[AX_Y]   <= goal_y;
            goal_reg[AX_YAW] <= goal_yaw;
            meas_reg[AX_X]   <= meas_x;
            meas_reg[AX_Y]   <= meas_y;
            meas_reg[AX_YAW] <= meas_yaw;
            dt_reg           <= step_time;
        end
    end

    // Axis counter and divider step count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg      <= AX_X;
            div_cnt_reg <= 6'd0;
        end
        else
        begin
            if (in_fire)
            begin
                ax_reg <= AX_X;
            end
            else if ((ctrl.dp == OP_CLAMP) && cond.ax_more)
            begin
                ax_reg <= ax_reg + 2'd1;
            end
            if (ctrl.dp == OP_UPD)
            begin
                div_cnt_reg <= DIV_STEPS;
            end
            else if (ctrl.dp == OP_DIV)
            begin
                div_cnt_reg <= div_cnt_reg - 6'd1;
            end
        end
    end

    // Last errors and running sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                last_reg[i] <= 32'sd0;
                sum_reg[i]  <= 48'sd0;
            end
        end
        else if (ctrl.dp == OP_UPD)
        begin
            last_reg[ax_reg] <= err_reg;
            sum_reg[ax_reg]  <= sum_sat;
        end
    end

    // Error, divider, rate and per-axis result registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.dp == OP_ERR)
        begin
            err_reg <= err_sat;
        end
        if (ctrl.dp == OP_UPD)
        begin
            rem_reg <= 31'd0;
            num_reg <= {dif_mag, 16'd0};
            neg_reg <= dif[32];
        end
        else if (ctrl.dp == OP_DIV)
        begin
            rem_reg <= div_ge ? div_sub[30:0] : trial[30:0];
            num_reg <= {num_reg[47:0], div_ge};
        end
        if (ctrl.dp == OP_RATE)
        begin
            rate_reg <= (dt_reg == 31'd0) ? 48'sd0 : rate_sat;
        end
        if (ctrl.dp == OP_CLAMP)
        begin
            velw_reg[ax_reg] <= clamp_val;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if ((ctrl.dp == OP_OUT) && !cond.out_busy)
        begin
            vel_x_reg   <= velw_reg[AX_X];
            vel_y_reg   <= velw_reg[AX_Y];
            vel_yaw_reg <= velw_reg[AX_YAW];
            zero_reg    <= (dt_reg == 31'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((ctrl.dp == OP_OUT) && !cond.out_busy)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;
    assign vel_yaw   = vel_yaw_reg;
    assign zero_time = zero_reg;

    // Checks on the sequencing.
    `PVC_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready, "input taken while busy")
    `PVC_ASSERT_IMP(a_div_count, ctrl.dp == OP_DIV, div_cnt_reg != 6'd0, "divider overrun")
    `PVC_ASSERT_NXT(a_last_axis_out, (ctrl.dp == OP_CLAMP) && !cond.ax_more, ctrl.dp == OP_OUT, "missed output step")
    `PVC_ASSERT_NXT(a_zero_rate, (ctrl.dp == OP_RATE) && (dt_reg == 31'd0), rate_reg == 48'sd0, "rate not zero for zero step time")

endmodule

// ===== tb/tb_three_axis_pid_velocity_core.sv =====
// Self-checking testbench for the three-axis PID velocity core.
`timescale 1ns / 1ps
module tb_three_axis_pid_velocity_core;
    import pvc_pkg::*;

    // Cycles without any accepted word, delivered result or register write before the run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    // Cycles to wait after the last result, just over the block's latency.
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned WORDS_PER_PHASE = 200;
    localparam int unsigned NUM_PHASES = 6;

    // One input word: target pose, measured pose and step time.
    typedef struct packed {
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gw;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] mw;
        logic [30:0]        dt;
    } pose_word_t;

    // One output word: velocity commands and the zero step time flag.
    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vw;
        logic               zt;
    } cmd_t;

    // One line of the directed table: a register write or an input word.
    typedef struct packed {
        logic       is_reg;
        cfg_idx_t   idx;
        logic [31:0] data;
        pose_word_t w;
        logic       has_exp;
        cmd_t       exp;
    } drive_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic        [2:0]  cfg_addr;
    logic        [31:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_yaw;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_yaw;
    logic        [30:0] step_time;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_yaw;
    logic               zero_time;

    // Predictor copy of the registers.
    logic [31:0] lin_kp, lin_ki, lin_kd;
    logic [31:0] ang_kp, ang_ki, ang_kd;
    logic [30:0] lin_lim, ang_lim;

    // Predictor copy of the per-axis state: x, y, yaw.
    logic signed [31:0] prev_err [3];
    logic signed [47:0] err_sum [3];

    cmd_t        pending_cmds[$];
    int unsigned mismatches;
    int unsigned idle_cycles;
    bit          idle_on;

    three_axis_pid_velocity_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .goal_x    (goal_x),
        .goal_y    (goal_y),
        .goal_yaw  (goal_yaw),
        .meas_x    (meas_x),
        .meas_y    (meas_y),
        .meas_yaw  (meas_yaw),
        .step_time (step_time),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_yaw   (vel_yaw),
        .zero_time (zero_time)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gain times a Q16.16 value, scaled back by 2^24 with rounding toward minus infinity.
    function automatic logic signed [83:0] gain_term(input longint v, input logic [31:0] g);
        logic signed [83:0] vv;
        logic signed [83:0] gg;
        vv = v;
        gg = {52'd0, g};
        return (vv * gg) >>> 24;
    endfunction

    // One axis of the controller; updates that axis's last error and running sum.
    function automatic logic signed [31:0] axis_cmd(input int ax,
                                                    input logic signed [31:0] goal,
                                                    input logic signed [31:0] meas,
                                                    input logic [30:0] dt,
                                                    input logic [31:0] kp,
                                                    input logic [31:0] ki,
                                                    input logic [31:0] kd,
                                                    input logic [30:0] lim);
        longint e;
        longint s;
        longint r;
        logic signed [83:0] total;
        logic signed [83:0] bound;
        e = longint'(goal) - longint'(meas);
        if (e > S32_MAX)
            e = S32_MAX;
        else if (e < S32_MIN)
            e = S32_MIN;
        s = longint'(err_sum[ax]) + e;
        if (s > S48_MAX)
            s = S48_MAX;
        else if (s < S48_MIN)
            s = S48_MIN;
        err_sum[ax] = s[47:0];
        // The rate is forced to zero when no time has passed.
        r = 0;
        if (dt != 0)
        begin
            r = ((e - longint'(prev_err[ax])) * 65536) / longint'(dt);
            if (r > S48_MAX)
                r = S48_MAX;
            else if (r < S48_MIN)
                r = S48_MIN;
        end
        prev_err[ax] = e[31:0];
        total = gain_term(e, kp) + gain_term(s, ki) + gain_term(r, kd);
        bound = {53'd0, lim};
        if (total > bound)
            total = bound;
        else if (total < -bound)
            total = -bound;
        return total[31:0];
    endfunction

    // Expected command for one accepted pose word.
    function automatic cmd_t predict_cmd(input pose_word_t w);
        cmd_t c;
        c.vx = axis_cmd(0, w.gx, w.mx, w.dt, lin_kp, lin_ki, lin_kd, lin_lim);
        c.vy = axis_cmd(1, w.gy, w.my, w.dt, lin_kp, lin_ki, lin_kd, lin_lim);
        c.vw = axis_cmd(2, w.gw, w.mw, w.dt, ang_kp, ang_ki, ang_kd, ang_lim);
        c.zt = (w.dt == 0);
        return c;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 8);
        else if (r < 97)
            return $urandom_range(9, 60);
        else
            return $urandom_range(61, 400);
    endfunction

    // Target and measurement for one axis, mixing small, large and full-scale errors.
    function automatic void rand_axis(output logic signed [31:0] g,
                                      output logic signed [31:0] m);
        int unsigned        r;
        logic signed [31:0] base;
        logic signed [31:0] e;
        r = $urandom_range(0, 99);
        base = $urandom_range(0, 32'h1FFF_FFFF);
        base = base - 32'sh1000_0000;
        if (r < 40)
        begin
            e = $urandom_range(0, 32'h1_FFFF);
            e = e - 32'sh1_0000;
            g = base;
            m = base - e;
        end
        else if (r < 60)
        begin
            e = $urandom_range(0, 32'h1FF_FFFF);
            e = e - 32'sh100_0000;
            g = base;
            m = base - e;
        end
        else if (r < 80)
        begin
            g = $urandom();
            m = $urandom();
        end
        else if (r < 90)
        begin
            g = $urandom_range(0, 1) ? S32_MAX : S32_MIN;
            case ($urandom_range(0, 2))
                0: m = S32_MAX;
                1: m = S32_MIN;
                default: m = '0;
            endcase
        end
        else
        begin
            g = base;
            m = base;
        end
    endfunction

    // Random pose word; step times cluster around typical odometry rates.
    function automatic pose_word_t rand_word();
        pose_word_t  w;
        int unsigned r;
        rand_axis(w.gx, w.mx);
        rand_axis(w.gy, w.my);
        rand_axis(w.gw, w.mw);
        r = $urandom_range(0, 99);
        if (r < 5)
            w.dt = '0;
        else if (r < 55)
            w.dt = 31'($urandom_range(600, 7000));
        else if (r < 70)
            w.dt = 31'($urandom_range(1, 255));
        else if (r < 85)
            w.dt = 31'($urandom_range(0, 1 << 20));
        else if (r < 95)
            w.dt = 31'($urandom());
        else
            w.dt = 31'h7FFF_FFFF;
        return w;
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            7, 8:    return $urandom_range(0, 32'h1000_0000);
            9:       return $urandom();
            default: return $urandom_range(0, 32'h0200_0000);
        endcase
    endfunction

    // Limit with a random top bit, which the register must drop.
    function automatic logic [31:0] rand_limit();
        logic [31:0] d;
        case ($urandom_range(0, 9))
            0:       d = '0;
            1:       d = 32'hFFFF_FFFF;
            7, 8:    d = $urandom_range(0, 32'h0100_0000);
            9:       d = $urandom();
            default: d = $urandom_range(0, 32'h0004_0000);
        endcase
        d[31] = 1'($urandom_range(0, 1));
        return d;
    endfunction

    function automatic drive_row_t word_row(input pose_word_t w);
        drive_row_t row;
        row = '0;
        row.w = w;
        return row;
    endfunction

    function automatic drive_row_t checked_row(input pose_word_t w, input cmd_t exp);
        drive_row_t row;
        row = '0;
        row.w = w;
        row.has_exp = 1'b1;
        row.exp = exp;
        return row;
    endfunction

    function automatic drive_row_t reg_row(input cfg_idx_t idx, input logic [31:0] d);
        drive_row_t row;
        row = '0;
        row.is_reg = 1'b1;
        row.idx = idx;
        row.data = d;
        return row;
    endfunction

    // Register write; the enable is lowered by whatever is driven next.
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] d);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= d;
        @(posedge clk);
        case (idx)
            CFG_LIN_P:   lin_kp = d;
            CFG_LIN_I:   lin_ki = d;
            CFG_LIN_D:   lin_kd = d;
            CFG_ANG_P:   ang_kp = d;
            CFG_ANG_I:   ang_ki = d;
            CFG_ANG_D:   ang_kd = d;
            CFG_LIN_LIM: lin_lim = d[30:0];
            CFG_ANG_LIM: ang_lim = d[30:0];
            default:     ;
        endcase
    endtask

    task automatic idle_gap(input int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            cfg_we   <= 1'b0;
        end
    endtask

    // Drop valid and wait until every expected command has come back.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        cfg_we   <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    // Present one word, hold it until accepted, then record the expected command.
    task automatic send_word(input pose_word_t w, input logic has_exp, input cmd_t exp);
        cmd_t c;
        if (idle_on)
            idle_gap(pick_gap());
        @(negedge clk);
        in_valid  <= 1'b1;
        cfg_we    <= 1'b0;
        goal_x    <= w.gx;
        goal_y    <= w.gy;
        goal_yaw  <= w.gw;
        meas_x    <= w.mx;
        meas_y    <= w.my;
        meas_yaw  <= w.mw;
        step_time <= w.dt;
        do
            @(posedge clk);
        while (!in_ready);
        c = predict_cmd(w);
        if (has_exp)
            c = exp;
        pending_cmds.push_back(c);
    endtask

    // Rewrites all eight registers: reset values, all at maximum, or random.
    task automatic load_regs(input int unsigned mode);
        cfg_idx_t    idx;
        logic [31:0] d;
        for (int i = 0; i < 8; i++)
        begin
            idx = cfg_idx_t'(i);
            if (mode == 1)
                d = 32'hFFFF_FFFF;
            else if (mode == 0)
            begin
                case (idx)
                    CFG_LIN_P:   d = RST_LIN_P;
                    CFG_LIN_I:   d = RST_LIN_I;
                    CFG_LIN_D:   d = RST_LIN_D;
                    CFG_ANG_P:   d = RST_ANG_P;
                    CFG_ANG_I:   d = RST_ANG_I;
                    CFG_ANG_D:   d = RST_ANG_D;
                    CFG_LIN_LIM: d = {1'b0, RST_LIN_LIM};
                    default:     d = {1'b0, RST_ANG_LIM};
                endcase
            end
            else if (idx == CFG_LIN_LIM || idx == CFG_ANG_LIM)
                d = rand_limit();
            else
                d = rand_gain();
            write_reg(idx, d);
        end
    endtask

    // Stimulus: reset, directed table, then random phases with fresh register settings.
    initial
    begin
        drive_row_t dir_rows[$];
        pose_word_t w;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_LIN_P;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        goal_x    <= '0;
        goal_y    <= '0;
        goal_yaw  <= '0;
        meas_x    <= '0;
        meas_y    <= '0;
        meas_yaw  <= '0;
        step_time <= '0;
        mismatches = 0;
        idle_on = 1'b1;
        lin_kp  = RST_LIN_P;
        lin_ki  = RST_LIN_I;
        lin_kd  = RST_LIN_D;
        ang_kp  = RST_ANG_P;
        ang_ki  = RST_ANG_I;
        ang_kd  = RST_ANG_D;
        lin_lim = RST_LIN_LIM;
        ang_lim = RST_ANG_LIM;
        for (int a = 0; a < 3; a++)
        begin
            prev_err[a] = '0;
            err_sum[a]  = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Zero error straight after reset, with and without elapsed time.
        dir_rows.push_back(checked_row('0, '{32'sd0, 32'sd0, 32'sd0, 1'b1}));
        dir_rows.push_back(checked_row('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                                         31'd65536}, '{32'sd0, 32'sd0, 32'sd0, 1'b0}));
        // Full-scale errors in both directions saturate and clamp at the limits.
        dir_rows.push_back(checked_row('{S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN,
                                         31'd65536},
                                       '{32'sd32768, 32'sd32768, 32'sd150733, 1'b0}));
        dir_rows.push_back(checked_row('{S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX,
                                         31'd1},
                                       '{-32'sd32768, -32'sd32768, -32'sd150733, 1'b0}));
        // Longest step time, zero step time with a live error, and a one-LSB negative error.
        dir_rows.push_back(word_row('{32'sd70000, -32'sd5000, 32'sd12345, 32'sd0, 32'sd0,
                                      32'sd0, 31'h7FFF_FFFF}));
        dir_rows.push_back(word_row('{32'sd40000, 32'sd20000, -32'sd9000, 32'sd0, 32'sd0,
                                      32'sd0, 31'd0}));
        dir_rows.push_back(word_row('{32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1,
                                      31'd1311}));
        // A zero limit forces every command to zero.
        dir_rows.push_back(reg_row(CFG_LIN_LIM, 32'd0));
        dir_rows.push_back(reg_row(CFG_ANG_LIM, 32'd0));
        dir_rows.push_back(checked_row('{S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, 32'sd7,
                                         31'd65536}, '{32'sd0, 32'sd0, 32'sd0, 1'b0}));
        // Oversized limits keep only their low 31 bits; gains at their maximum.
        dir_rows.push_back(reg_row(CFG_LIN_LIM, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(CFG_ANG_LIM, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(CFG_LIN_P, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(CFG_LIN_I, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(CFG_LIN_D, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(CFG_ANG_P, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(CFG_ANG_I, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(CFG_ANG_D, 32'hFFFF_FFFF));
        dir_rows.push_back(word_row('{S32_MAX, S32_MIN, 32'sd3, S32_MIN, S32_MAX, 32'sd0,
                                      31'd1}));
        dir_rows.push_back(word_row('{S32_MIN, S32_MAX, -32'sd3, S32_MAX, S32_MIN, 32'sd0,
                                      31'd1}));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_reg)
            begin
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
                send_word(dir_rows[i].w, dir_rows[i].has_exp, dir_rows[i].exp);
        end

        // Random phases; one of them runs with no idling on either side.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            load_regs(ph);
            idle_on = (ph != 2);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                w = rand_word();
                send_word(w, 1'b0, '0);
            end
        end
        idle_on = 1'b1;

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[three_axis_pid_velocity_core] OK");
        else
            $display("[three_axis_pid_velocity_core] ERROR");
        $finish;
    end

    // Result side back-pressure.
    initial
    begin
        int unsigned stall;
        stall = 0;
        out_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    stall = pick_gap();
            end
        end
    end

    task automatic check_field(input string what, input logic signed [31:0] exp,
                               input logic signed [31:0] act);
        if (exp !== act)
        begin
            mismatches++;
            $display("%0t %s: expected %0d, got %0d", $time, what, exp, act);
        end
    endtask

    // Compare each delivered word with the oldest pending command.
    always @(posedge clk)
    begin
        cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                $display("%0t result word with none expected: %0d %0d %0d %0d", $time,
                         vel_x, vel_y, vel_yaw, zero_time);
            end
            else
            begin
                want = pending_cmds.pop_front();
                check_field("vel_x", want.vx, vel_x);
                check_field("vel_y", want.vy, vel_y);
                check_field("vel_yaw", want.vw, vel_yaw);
                check_field("zero_time", {31'd0, want.zt}, {31'd0, zero_time});
            end
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("[three_axis_pid_velocity_core] ERROR");
            $finish;
        end
    end

endmodule
